>>> rtl/click_and_long_press_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the click and long-press detector
// Implication checks on the rising clock edge, off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CLICK_AND_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`define CLICK_AND_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CLD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cldet_pkg.sv
// ----------------------------------------------------------------------------
// cldet_pkg
// Types and constants shared by the click and long-press detector.
// ----------------------------------------------------------------------------
package cldet_pkg;

  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_POLL    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_CLICK_GAP  = 2'd1,
    CFG_DEBOUNCE   = 2'd2,
    CFG_MAX_CLICKS = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] LongPressRst = 16'd5000;
  localparam logic [15:0] ClickGapRst  = 16'd600;
  localparam logic [9:0]  DebounceRst  = 10'd50;
  localparam logic [2:0]  MaxClicksRst = 3'd5;
  localparam logic [2:0]  ClickCap     = 3'd7;

  typedef struct packed {
    logic [15:0] hold_long_ms;
    logic [15:0] click_gap_ms;
    logic [9:0]  min_hold_ms;
    logic [2:0]  max_clicks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic       run_done;
    logic [2:0] run_clicks;
    logic       long_press;
  } res_t;

endpackage

>>> rtl/cldet_core.sv
// ----------------------------------------------------------------------------
// cldet_core
// Button state and per-event decision logic; one event per enabled cycle.
// ----------------------------------------------------------------------------
`include "click_and_long_press_detector_unit_assert.svh"

module cldet_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  cldet_pkg::evt_t   evt_i,
  input  cldet_pkg::cfg_t   cfg_i,
  output cldet_pkg::res_t   res_o
);

  logic [cldet_pkg::TimeW-1:0] press_start_q, press_start_d;
  logic [cldet_pkg::TimeW-1:0] release_time_q, release_time_d;
  logic                        is_pressed_q, is_pressed_d;
  logic                        long_fired_q, long_fired_d;
  logic [2:0]                  click_total_q, click_total_d;

  logic [cldet_pkg::TimeW-1:0] hold_dur;
  logic [cldet_pkg::TimeW-1:0] gap_dur;
  logic [2:0]                  click_inc;
  logic                        hold_long;
  cldet_pkg::res_t             res;

  assign hold_dur  = evt_i.now_ms - press_start_q;
  assign gap_dur   = evt_i.now_ms - release_time_q;
  assign click_inc = click_total_q + 3'd1;
  assign hold_long = hold_dur >= {{(cldet_pkg::TimeW-16){1'b0}}, cfg_i.hold_long_ms};

  always_comb begin
    press_start_d  = press_start_q;
    release_time_d = release_time_q;
    is_pressed_d   = is_pressed_q;
    long_fired_d   = long_fired_q;
    click_total_d  = click_total_q;
    res            = '0;
    case (evt_i.kind)
      cldet_pkg::KIND_PRESS: begin
        press_start_d = evt_i.now_ms;
        is_pressed_d  = 1'b1;
        long_fired_d  = 1'b0;
      end
      cldet_pkg::KIND_RELEASE: begin
        if (is_pressed_q) begin
          is_pressed_d = 1'b0;
          if (hold_dur >= {{(cldet_pkg::TimeW-10){1'b0}}, cfg_i.min_hold_ms}) begin
            if (hold_long && !long_fired_q) begin
              long_fired_d   = 1'b1;
              click_total_d  = '0;
              res.long_press = 1'b1;
            end else if (long_fired_q) begin
              long_fired_d = 1'b0;
            end else begin
              click_total_d  = click_inc;
              release_time_d = evt_i.now_ms;
              if (click_inc >= cfg_i.max_clicks || click_inc == cldet_pkg::ClickCap) begin
                res.run_done   = 1'b1;
                res.run_clicks = click_inc;
                click_total_d  = '0;
              end
            end
          end
        end
      end
      cldet_pkg::KIND_POLL: begin
        if (click_total_q != 3'd0 &&
            gap_dur >= {{(cldet_pkg::TimeW-16){1'b0}}, cfg_i.click_gap_ms}) begin
          res.run_done   = 1'b1;
          res.run_clicks = click_total_q;
          click_total_d  = '0;
        end
        if (is_pressed_q && !long_fired_q && hold_long) begin
          long_fired_d   = 1'b1;
          click_total_d  = '0;
          is_pressed_d   = 1'b0;
          res.long_press = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_start_q  <= '0;
      release_time_q <= '0;
      is_pressed_q   <= 1'b0;
      long_fired_q   <= 1'b0;
      click_total_q  <= '0;
    end else if (adv_i) begin
      press_start_q  <= press_start_d;
      release_time_q <= release_time_d;
      is_pressed_q   <= is_pressed_d;
      long_fired_q   <= long_fired_d;
      click_total_q  <= click_total_d;
    end
  end

  `CLD_ASSERT_IMP(a_done_has_clicks, clk_i, rst_ni, adv_i && res.run_done,
                  res.run_clicks != 3'd0)
  `CLD_ASSERT_NXT(a_long_closes, clk_i, rst_ni, adv_i && res.long_press,
                  !is_pressed_q && long_fired_q)
  `CLD_ASSERT_NXT(a_done_clears, clk_i, rst_ni, adv_i && res.run_done,
                  click_total_q == 3'd0)
  `CLD_ASSERT_NXT(a_press_opens, clk_i, rst_ni, adv_i && evt_i.kind == cldet_pkg::KIND_PRESS,
                  is_pressed_q && !long_fired_q)

endmodule

>>> rtl/click_and_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// click_and_long_press_detector_unit
// Button multi-click and long-press detector with registered in/out stages.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one button item (kind_i,
// now_ms_i). An item is taken at an edge with in_valid_i high and in_stall_o
// low. Every item yields exactly one result item on the output channel
// (run_done_o, run_clicks_o, long_press_o), taken at an edge with out_valid_o
// high and out_stall_i low.
// An item passes the input register, then the decision logic feeding the
// result register. One item per cycle is sustained while out_stall_i is low;
// the rate is set by the core, which updates its state as each item advances.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i selecting
// long-press time, click gap, debounce time, max clicks; ready is always high.
// Write configuration only while no item is in flight.
// Reset clears the button state and loads the default configuration; both
// stages come up empty. A stalled receiver holds the result register, and the
// input register fills and then raises in_stall_o.
// ----------------------------------------------------------------------------
`include "click_and_long_press_detector_unit_assert.svh"

module click_and_long_press_detector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [cldet_pkg::TimeW-1:0] now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        run_done_o,
  output logic [2:0]                  run_clicks_o,
  output logic                        long_press_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [15:0]                 cfg_wdata_i
);

  logic            in_valid_q, in_valid_d;
  cldet_pkg::evt_t evt_q;
  logic            out_valid_q, out_valid_d;
  cldet_pkg::res_t res_q;
  cldet_pkg::res_t res;
  cldet_pkg::cfg_t cfg_q;
  logic            adv;
  logic            in_take;

  assign adv         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      evt_q.kind   <= kind_i;
      evt_q.now_ms <= now_ms_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_long_ms <= cldet_pkg::LongPressRst;
      cfg_q.click_gap_ms <= cldet_pkg::ClickGapRst;
      cfg_q.min_hold_ms  <= cldet_pkg::DebounceRst;
      cfg_q.max_clicks   <= cldet_pkg::MaxClicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cldet_pkg::CFG_LONG_PRESS: cfg_q.hold_long_ms <= cfg_wdata_i;
        cldet_pkg::CFG_CLICK_GAP:  cfg_q.click_gap_ms <= cfg_wdata_i;
        cldet_pkg::CFG_DEBOUNCE:   cfg_q.min_hold_ms  <= cfg_wdata_i[9:0];
        cldet_pkg::CFG_MAX_CLICKS: cfg_q.max_clicks   <= cfg_wdata_i[2:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  cldet_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .evt_i  (evt_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o  = out_valid_q;
  assign run_done_o   = res_q.run_done;
  assign run_clicks_o = res_q.run_clicks;
  assign long_press_o = res_q.long_press;

  `CLD_ASSERT_NXT(a_adv_fills_out, clk_i, rst_ni, adv, out_valid_q)
  `CLD_ASSERT_IMP(a_out_idle_zero, clk_i, rst_ni, out_valid_q && !res_q.run_done,
                  res_q.run_clicks == 3'd0)
  `CLD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i,
                  out_valid_q && $stable(res_q))

endmodule

>>> tb/click_and_long_press_detector_unit_test.sv
// ----------------------------------------------------------------------------
// click_and_long_press_detector_unit_test
// Drives timestamped press, release and poll items into the detector and
// checks every result item against a cycle-free model of the button state.
// A short directed run covers debounce, long press on poll and on release,
// gap expiry, wraparound and both flags in one poll, then random gestures
// run under several register settings with bursty valid and stall.
// ----------------------------------------------------------------------------
module click_and_long_press_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimeW      = cldet_pkg::TimeW;
  localparam logic [1:0]  KindSpare  = 2'd3;
  localparam int          QuietLimit = 2000;
  localparam int          PhaseItems = 235;
  localparam int          PhaseCount = 6;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           kind_i       = '0;
  logic [TimeW-1:0]     now_ms_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 run_done_o;
  logic [2:0]           run_clicks_o;
  logic                 long_press_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i  = '0;
  logic [15:0]          cfg_wdata_i  = '0;

  cldet_pkg::evt_t      button_items[$];
  cldet_pkg::res_t      awaited_results[$];
  cldet_pkg::evt_t      next_item;
  cldet_pkg::res_t      want;
  cldet_pkg::cfg_t      live_cfg;

  logic [TimeW-1:0]     held_since;
  logic                 btn_down;
  logic                 long_sent;
  logic [2:0]           click_run;
  logic [TimeW-1:0]     last_click_at;

  logic [TimeW-1:0]     stamp;
  int                   phase_items;
  int                   idle_pct;
  bit                   hold_send;
  int                   gap_left;
  int                   stall_left;
  int                   quiet_cycles;
  int                   mismatch_count;

  click_and_long_press_detector_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_done_o   (run_done_o),
    .run_clicks_o (run_clicks_o),
    .long_press_o (long_press_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic cldet_pkg::res_t judge_event(logic [1:0] kind,
                                                  logic [TimeW-1:0] now);
    cldet_pkg::res_t  r;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] quiet;
    r = '0;
    held = now - held_since;
    quiet = now - last_click_at;
    case (kind)
      cldet_pkg::KIND_PRESS: begin
        held_since = now;
        btn_down = 1'b1;
        long_sent = 1'b0;
      end
      cldet_pkg::KIND_RELEASE: begin
        if (btn_down) begin
          btn_down = 1'b0;
          if (held >= live_cfg.min_hold_ms) begin
            if (held >= live_cfg.hold_long_ms && !long_sent) begin
              long_sent = 1'b1;
              click_run = '0;
              r.long_press = 1'b1;
            end else if (long_sent) begin
              long_sent = 1'b0;
            end else begin
              click_run = click_run + 3'd1;
              last_click_at = now;
              if (click_run >= live_cfg.max_clicks || click_run == cldet_pkg::ClickCap) begin
                r.run_done = 1'b1;
                r.run_clicks = click_run;
                click_run = '0;
              end
            end
          end
        end
      end
      cldet_pkg::KIND_POLL: begin
        if (click_run != 3'd0 && quiet >= live_cfg.click_gap_ms) begin
          r.run_done = 1'b1;
          r.run_clicks = click_run;
          click_run = '0;
        end
        if (btn_down && !long_sent && held >= live_cfg.hold_long_ms) begin
          long_sent = 1'b1;
          click_run = '0;
          btn_down = 1'b0;
          r.long_press = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [TimeW-1:0] near(logic [TimeW-1:0] mark);
    case ($urandom_range(0, 5))
      0:       return (mark == 0) ? mark : mark - 1;
      1:       return mark;
      2:       return mark + 1;
      3:       return $urandom_range(0, mark);
      4:       return $urandom_range(mark, 2 * mark + 1);
      default: return $urandom_range(0, 2 * mark + 1);
    endcase
  endfunction

  task automatic add_item(logic [1:0] kind, logic [TimeW-1:0] at);
    cldet_pkg::evt_t e;
    e.kind = kind;
    e.now_ms = at;
    button_items.push_back(e);
    if (kind != KindSpare) phase_items++;
  endtask

  task automatic click_at(logic [TimeW-1:0] at);
    logic [TimeW-1:0] span;
    if (live_cfg.hold_long_ms > live_cfg.min_hold_ms)
      span = $urandom_range(live_cfg.min_hold_ms, live_cfg.hold_long_ms - 1);
    else
      span = TimeW'(live_cfg.min_hold_ms);
    add_item(cldet_pkg::KIND_PRESS, at);
    if ($urandom_range(0, 4) == 0) add_item(cldet_pkg::KIND_POLL, at + $urandom_range(0, span));
    add_item(cldet_pkg::KIND_RELEASE, at + span);
    stamp = at + span;
  endtask

  task automatic add_gesture();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      click_at(stamp);
      if ($urandom_range(0, 2) == 0)
        stamp += near(TimeW'(live_cfg.click_gap_ms));
      else
        stamp += $urandom_range(0, live_cfg.click_gap_ms);
      if ($urandom_range(0, 3) == 0) add_item(cldet_pkg::KIND_POLL, stamp);
    end else if (pick < 13) begin
      add_item(cldet_pkg::KIND_PRESS, stamp);
      if ($urandom_range(0, 1))
        add_item(cldet_pkg::KIND_POLL, stamp + near(TimeW'(live_cfg.hold_long_ms)));
      stamp += near(TimeW'(live_cfg.hold_long_ms));
      add_item($urandom_range(0, 1) ? cldet_pkg::KIND_RELEASE : cldet_pkg::KIND_POLL, stamp);
      if ($urandom_range(0, 1))
        add_item(cldet_pkg::KIND_RELEASE, stamp + $urandom_range(0, 100));
    end else if (pick < 16) begin
      stamp += near(TimeW'(live_cfg.click_gap_ms));
      add_item(cldet_pkg::KIND_POLL, stamp);
    end else if (pick < 18) begin
      add_item(cldet_pkg::KIND_PRESS, stamp);
      stamp += near(TimeW'(live_cfg.min_hold_ms));
      add_item(cldet_pkg::KIND_RELEASE, stamp);
    end else begin
      add_item(2'($urandom_range(0, 3)), $urandom());
      if ($urandom_range(0, 3) == 0) stamp = $urandom();
    end
  endtask

  task automatic write_reg(cldet_pkg::cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cldet_pkg::CFG_LONG_PRESS: live_cfg.hold_long_ms = val;
      cldet_pkg::CFG_CLICK_GAP:  live_cfg.click_gap_ms = val;
      cldet_pkg::CFG_DEBOUNCE:   live_cfg.min_hold_ms  = val[9:0];
      cldet_pkg::CFG_MAX_CLICKS: live_cfg.max_clicks   = val[2:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] lp, logic [15:0] gap, logic [15:0] deb,
                          logic [15:0] most);
    write_reg(cldet_pkg::CFG_LONG_PRESS, lp);
    write_reg(cldet_pkg::CFG_CLICK_GAP, gap);
    write_reg(cldet_pkg::CFG_DEBOUNCE, deb);
    write_reg(cldet_pkg::CFG_MAX_CLICKS, most);
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (button_items.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= '0;
      now_ms_i <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(judge_event(kind_i, now_ms_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (!hold_send && button_items.size() != 0) begin
          next_item = button_items.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= next_item.kind;
          now_ms_i <= next_item.now_ms;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no item outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (run_done_o !== want.run_done) begin
            $error("run_done: expected %0d, got %0d", want.run_done, run_done_o);
            mismatch_count++;
          end
          if (run_clicks_o !== want.run_clicks) begin
            $error("run_clicks: expected %0d, got %0d", want.run_clicks, run_clicks_o);
            mismatch_count++;
          end
          if (long_press_o !== want.long_press) begin
            $error("long_press: expected %0d, got %0d", want.long_press, long_press_o);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    live_cfg.hold_long_ms = cldet_pkg::LongPressRst;
    live_cfg.click_gap_ms = cldet_pkg::ClickGapRst;
    live_cfg.min_hold_ms = cldet_pkg::DebounceRst;
    live_cfg.max_clicks = cldet_pkg::MaxClicksRst;
    held_since = '0;
    btn_down = 1'b0;
    long_sent = 1'b0;
    click_run = '0;
    last_click_at = '0;
    phase_items = 0;
    idle_pct = 20;
    hold_send = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_item(cldet_pkg::KIND_RELEASE, 32'd100);
    add_item(KindSpare, 32'hFFFF_FFFF);
    add_item(cldet_pkg::KIND_POLL, 32'd0);
    add_item(cldet_pkg::KIND_PRESS, 32'd1000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd1049);
    add_item(cldet_pkg::KIND_PRESS, 32'd2000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd2050);
    add_item(cldet_pkg::KIND_PRESS, 32'd2100);
    add_item(cldet_pkg::KIND_RELEASE, 32'd2200);
    add_item(cldet_pkg::KIND_POLL, 32'd2799);
    add_item(cldet_pkg::KIND_POLL, 32'd2800);
    add_item(cldet_pkg::KIND_PRESS, 32'd3000);
    add_item(cldet_pkg::KIND_POLL, 32'd7999);
    add_item(cldet_pkg::KIND_POLL, 32'd8000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd8100);
    add_item(cldet_pkg::KIND_PRESS, 32'd9000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd14000);
    add_item(cldet_pkg::KIND_PRESS, 32'hFFFF_FF00);
    add_item(cldet_pkg::KIND_RELEASE, 32'h0000_0040);
    add_item(cldet_pkg::KIND_POLL, 32'h0000_0298);
    add_item(cldet_pkg::KIND_PRESS, 32'd40000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd40100);
    add_item(cldet_pkg::KIND_PRESS, 32'd40200);
    add_item(cldet_pkg::KIND_POLL, 32'd45200);
    add_item(cldet_pkg::KIND_PRESS, 32'd50000);
    add_item(cldet_pkg::KIND_RELEASE, 32'd50100);
    add_item(cldet_pkg::KIND_PRESS, 32'd50200);
    add_item(cldet_pkg::KIND_RELEASE, 32'd50300);
    settle();
    stamp = 32'd60000;

    for (int p = 1; p <= PhaseCount; p++) begin
      case (p)
        1: set_regs(16'd200, 16'd150, 16'd20, 16'd2);
        2: set_regs(16'hFFFF, 16'hFFFF, 16'd1023, 16'd7);
        3: set_regs(16'd1, 16'd1, 16'd0, 16'd1);
        4: set_regs(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 2000)),
                    16'($urandom_range(0, 300)), 16'd0);
        5: set_regs(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 2000)),
                    16'($urandom_range(0, 1023)), 16'($urandom_range(0, 7)));
        default: set_regs(cldet_pkg::LongPressRst, cldet_pkg::ClickGapRst,
                          16'(cldet_pkg::DebounceRst), 16'(cldet_pkg::MaxClicksRst));
      endcase
      @(negedge clk_i);
      case (p)
        1: idle_pct = 25;
        2: idle_pct = 15;
        3: idle_pct = 0;
        4: idle_pct = 30;
        5: idle_pct = 20;
        default: idle_pct = 0;
      endcase
      if (p == 3) stamp = 32'hFFF0_0000;
      phase_items = 0;
      if (p == 1) click_at(stamp + 32'd100);
      while (phase_items < PhaseItems) add_gesture();
      if (p == 1) begin
        while (button_items.size() > PhaseItems / 2) @(negedge clk_i);
        hold_send = 1'b1;
        do @(negedge clk_i); while (in_valid_i || awaited_results.size() != 0);
        hold_send = 1'b0;
      end
      settle();
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cldet_pkg.sv
rtl/cldet_core.sv
rtl/click_and_long_press_detector_unit.sv
tb/click_and_long_press_detector_unit_test.sv
